FILE: hdl/ellipse_perimeter_approx_defines.svh
// Assertion helpers for the ellipse perimeter block
`ifndef ELLIPSE_PERIMETER_APPROX_DEFINES_SVH
`define ELLIPSE_PERIMETER_APPROX_DEFINES_SVH

// antecedent holds in this cycle, consequent in the same cycle
`define EPA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds in this cycle, consequent in the next
`define EPA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/epa_pkg.sv
`default_nettype none
package epa_pkg;
    localparam int Q        = 30;
    localparam int ROOT_W   = 32;
    localparam int RAD_W    = 64;
    localparam int SQ_REM_W = 34;
    localparam int DEN2_W   = 34;
    localparam logic [31:0] PI_Q30 = 32'd3373259426;
endpackage
`default_nettype wire

FILE: hdl/ellipse_perimeter_approx.sv
// Pipeline from an accepted request to o_valid: input stage, 30 divider cells,
// square, 32 root cells, 30 divider cells, two multiply stages, output register.
// Throughput: one request per cycle while the skid is empty, in every cell chain.
// A two-entry output register and skid keep input accepted until the skid fills.
// Reset: synchronous, active low, clears all valid bits; data registers keep value.
`default_nettype none
`include "ellipse_perimeter_approx_defines.svh"
module ellipse_perimeter_approx
    import epa_pkg::*;
#(
    parameter int LENGTH_WIDTH = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic [LENGTH_WIDTH-1:0] i_axis_a,
    input  wire logic [LENGTH_WIDTH-1:0] i_axis_b,
    input  wire logic                    i_given_as_radii,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic [LENGTH_WIDTH+2:0]      o_perimeter_value,
    output logic                         o_degenerate
);
    localparam int LW  = LENGTH_WIDTH;
    localparam int SL  = LW + 1;
    localparam int OW  = LW + 3;
    localparam int N1  = Q;
    localparam int N2  = ROOT_W;
    localparam int N3  = Q;
    localparam int HW  = Q + 1;
    localparam int GW  = Q + 3;
    localparam int PW  = SL + GW + 1;
    localparam int SW2 = 1 + SL + HW;
    localparam int SW3 = 1 + SL;

    logic w_en;

    // input stage
    logic [LW-1:0] w_a;
    logic [LW-1:0] w_b;
    logic [SL-1:0] w_s;
    logic [SL-1:0] w_d;
    logic          r_iv;
    logic [SL-1:0] r_s;
    logic [SL-1:0] r_d;
    logic          r_deg;

    assign w_a = (i_given_as_radii && i_axis_a[LW-1]) ? {LW{1'b1}} :
                 i_given_as_radii ? {i_axis_a[LW-2:0], 1'b0} : i_axis_a;
    assign w_b = (i_given_as_radii && i_axis_b[LW-1]) ? {LW{1'b1}} :
                 i_given_as_radii ? {i_axis_b[LW-2:0], 1'b0} : i_axis_b;
    assign w_s = {1'b0, w_a} + {1'b0, w_b};
    assign w_d = (w_a > w_b) ? ({1'b0, w_a} - {1'b0, w_b}) : ({1'b0, w_b} - {1'b0, w_a});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (w_en) begin
            r_iv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s   <= w_s;
            r_d   <= w_d;
            r_deg <= (w_s == '0);
        end
    end

    // r = d / s
    logic          c1_vld  [N1+1];
    logic [SL-1:0] c1_rem  [N1+1];
    logic [SL-1:0] c1_den  [N1+1];
    logic [Q-1:0]  c1_quo  [N1+1];
    logic [0:0]    c1_side [N1+1];

    assign c1_vld[0]  = r_iv;
    assign c1_rem[0]  = r_d;
    assign c1_den[0]  = r_s;
    assign c1_quo[0]  = '0;
    assign c1_side[0] = r_deg;

    for (genvar k = 0; k < N1; k++) begin : g_div1
        epa_div_cell #(.DW(SL), .SW(1)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (c1_vld[k]),
            .i_rem  (c1_rem[k]),
            .i_den  (c1_den[k]),
            .i_quo  (c1_quo[k]),
            .i_side (c1_side[k]),
            .o_vld  (c1_vld[k+1]),
            .o_rem  (c1_rem[k+1]),
            .o_den  (c1_den[k+1]),
            .o_quo  (c1_quo[k+1]),
            .o_side (c1_side[k+1])
        );
    end

    // h = round(r*r)
    logic [2*Q-1:0] w_sq;
    logic [2*Q:0]   w_rr;
    logic           r_hv;
    logic [HW-1:0]  r_h;
    logic [SL-1:0]  r_hs;
    logic           r_hdeg;

    assign w_sq = (2*Q)'(c1_quo[N1]) * (2*Q)'(c1_quo[N1]);
    assign w_rr = {1'b0, w_sq} + ((2*Q+1)'(1) << (Q - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0;
        end else if (w_en) begin
            r_hv <= c1_vld[N1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_h    <= w_rr[2*Q:Q];
            r_hs   <= c1_den[N1];
            r_hdeg <= c1_side[N1][0];
        end
    end

    // root = isqrt((4 - 3h) << 60 scale)
    logic [Q+2:0]       w_h3;
    logic [Q+2:0]       w_x;
    logic               c2_vld  [N2+1];
    logic [RAD_W-1:0]   c2_rad  [N2+1];
    logic [SQ_REM_W-1:0] c2_rem [N2+1];
    logic [ROOT_W-1:0]  c2_root [N2+1];
    logic [SW2-1:0]     c2_side [N2+1];

    assign w_h3 = {1'b0, r_h, 1'b0} + {2'b00, r_h};
    assign w_x  = ((Q+3)'(4) << Q) - w_h3;

    assign c2_vld[0]  = r_hv;
    assign c2_rad[0]  = {{(RAD_W-Q-Q-3){1'b0}}, w_x, {Q{1'b0}}};
    assign c2_rem[0]  = '0;
    assign c2_root[0] = '0;
    assign c2_side[0] = {r_hdeg, r_hs, r_h};

    for (genvar k = 0; k < N2; k++) begin : g_sqrt
        epa_sqrt_cell #(.SW(SW2)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (c2_vld[k]),
            .i_rad  (c2_rad[k]),
            .i_rem  (c2_rem[k]),
            .i_root (c2_root[k]),
            .i_side (c2_side[k]),
            .o_vld  (c2_vld[k+1]),
            .o_rad  (c2_rad[k+1]),
            .o_rem  (c2_rem[k+1]),
            .o_root (c2_root[k+1]),
            .o_side (c2_side[k+1])
        );
    end

    // q = 3h / (10 + root)
    logic [HW-1:0]     w_h2;
    logic [Q+2:0]      w_num2;
    logic              c3_vld  [N3+1];
    logic [DEN2_W-1:0] c3_rem  [N3+1];
    logic [DEN2_W-1:0] c3_den  [N3+1];
    logic [Q-1:0]      c3_quo  [N3+1];
    logic [SW3-1:0]    c3_side [N3+1];

    assign w_h2   = c2_side[N2][HW-1:0];
    assign w_num2 = {1'b0, w_h2, 1'b0} + {2'b00, w_h2};

    assign c3_vld[0]  = c2_vld[N2];
    assign c3_rem[0]  = DEN2_W'(w_num2);
    assign c3_den[0]  = (DEN2_W'(10) << Q) + DEN2_W'(c2_root[N2]);
    assign c3_quo[0]  = '0;
    assign c3_side[0] = c2_side[N2][SW2-1:HW];

    for (genvar k = 0; k < N3; k++) begin : g_div2
        epa_div_cell #(.DW(DEN2_W), .SW(SW3)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_vld  (c3_vld[k]),
            .i_rem  (c3_rem[k]),
            .i_den  (c3_den[k]),
            .i_quo  (c3_quo[k]),
            .i_side (c3_side[k]),
            .o_vld  (c3_vld[k+1]),
            .o_rem  (c3_rem[k+1]),
            .o_den  (c3_den[k+1]),
            .o_quo  (c3_quo[k+1]),
            .o_side (c3_side[k+1])
        );
    end

    // g = round(pi * (1 + q))
    logic [2*Q+2:0] w_gprod;
    logic [2*Q+3:0] w_gp;
    logic           r_gv;
    logic [GW-1:0]  r_g;
    logic [SL-1:0]  r_gs;
    logic           r_gdeg;

    assign w_gprod = (2*Q+3)'({1'b1, c3_quo[N3]}) * (2*Q+3)'(PI_Q30);
    assign w_gp    = {1'b0, w_gprod} + ((2*Q+4)'(1) << (Q - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gv <= 1'b0;
        end else if (w_en) begin
            r_gv <= c3_vld[N3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g    <= w_gp[Q+GW-1:Q];
            r_gs   <= c3_side[N3][SL-1:0];
            r_gdeg <= c3_side[N3][SL];
        end
    end

    // P = round(s * g), saturate, force zero when degenerate
    logic [SL+GW-1:0] w_pprod;
    logic [PW-1:0]    w_pp;
    logic [PW-Q-1:0]  w_pf;
    logic             r_pv;
    logic [OW-1:0]    r_p;
    logic             r_pdeg;

    assign w_pprod = (SL+GW)'(r_gs) * (SL+GW)'(r_g);
    assign w_pp    = {1'b0, w_pprod} + (PW'(1) << (Q - 1));
    assign w_pf    = w_pp[PW-1:Q];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (w_en) begin
            r_pv <= r_gv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_gdeg) begin
                r_p <= '0;
            end else if (w_pf[PW-Q-1:OW] != '0) begin
                r_p <= {OW{1'b1}};
            end else begin
                r_p <= w_pf[OW-1:0];
            end
            r_pdeg <= r_gdeg;
        end
    end

    // output register and skid entry
    logic          r_out_vld;
    logic [OW-1:0] r_out_p;
    logic          r_out_deg;
    logic          r_skid_vld;
    logic [OW-1:0] r_skid_p;
    logic          r_skid_deg;

    assign w_en = !r_skid_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld <= r_pv;
            end
        end else if (r_pv && w_en) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_vld || i_ready) begin
            if (r_skid_vld) begin
                r_out_p   <= r_skid_p;
                r_out_deg <= r_skid_deg;
            end else begin
                r_out_p   <= r_p;
                r_out_deg <= r_pdeg;
            end
        end else if (r_pv && w_en) begin
            r_skid_p   <= r_p;
            r_skid_deg <= r_pdeg;
        end
    end

    assign o_ready           = w_en;
    assign o_valid           = r_out_vld;
    assign o_perimeter_value = r_out_p;
    assign o_degenerate      = r_out_deg;

    `EPA_ASSERT_NOW(a_deg_zero, o_valid && o_degenerate, o_perimeter_value == '0,
        "degenerate result with nonzero perimeter")
    `EPA_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld,
        "skid entry held while output register empty")
    `EPA_ASSERT_NEXT(a_skid_fill, !r_skid_vld && !(o_valid && !i_ready), !r_skid_vld,
        "skid filled without a stalled output")
endmodule
`default_nettype wire

FILE: hdl/epa_div_cell.sv
`default_nettype none
module epa_div_cell
    import epa_pkg::*;
#(
    parameter int DW = 17,
    parameter int SW = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_vld,
    input  wire logic [DW-1:0] i_rem,
    input  wire logic [DW-1:0] i_den,
    input  wire logic [Q-1:0]  i_quo,
    input  wire logic [SW-1:0] i_side,
    output logic               o_vld,
    output logic [DW-1:0]      o_rem,
    output logic [DW-1:0]      o_den,
    output logic [Q-1:0]       o_quo,
    output logic [SW-1:0]      o_side
);
    logic [DW:0]   w_t;
    logic [DW:0]   w_diff;
    logic          w_ge;
    logic          r_vld;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [Q-1:0]  r_quo;
    logic [SW-1:0] r_side;

    assign w_t    = {i_rem, 1'b0};
    assign w_ge   = (w_t >= {1'b0, i_den});
    assign w_diff = w_t - {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? w_diff[DW-1:0] : w_t[DW-1:0];
            r_den  <= i_den;
            r_quo  <= {i_quo[Q-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_den  = r_den;
    assign o_quo  = r_quo;
    assign o_side = r_side;
endmodule
`default_nettype wire

FILE: hdl/epa_sqrt_cell.sv
`default_nettype none
module epa_sqrt_cell
    import epa_pkg::*;
#(
    parameter int SW = 1
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_en,
    input  wire logic                i_vld,
    input  wire logic [RAD_W-1:0]    i_rad,
    input  wire logic [SQ_REM_W-1:0] i_rem,
    input  wire logic [ROOT_W-1:0]   i_root,
    input  wire logic [SW-1:0]       i_side,
    output logic                     o_vld,
    output logic [RAD_W-1:0]         o_rad,
    output logic [SQ_REM_W-1:0]      o_rem,
    output logic [ROOT_W-1:0]        o_root,
    output logic [SW-1:0]            o_side
);
    logic [SQ_REM_W+1:0] w_t;
    logic [SQ_REM_W+1:0] w_trial;
    logic [SQ_REM_W+1:0] w_diff;
    logic                w_ge;
    logic                r_vld;
    logic [RAD_W-1:0]    r_rad;
    logic [SQ_REM_W-1:0] r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [SW-1:0]       r_side;

    // bring down the next two radicand bits, try (root*4 + 1)
    assign w_t     = {i_rem, i_rad[RAD_W-1 -: 2]};
    assign w_trial = {{(SQ_REM_W-ROOT_W){1'b0}}, i_root, 2'b01};
    assign w_ge    = (w_t >= w_trial);
    assign w_diff  = w_t - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad  <= {i_rad[RAD_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff[SQ_REM_W-1:0] : w_t[SQ_REM_W-1:0];
            r_root <= {i_root[ROOT_W-2:0], w_ge};
            r_side <= i_side;
        end
    end

    assign o_vld  = r_vld;
    assign o_rad  = r_rad;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_side = r_side;
endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
`default_nettype none

class perimeter_scoreboard;
    typedef struct packed {
        logic [18:0] perimeter;
        logic        degenerate;
    } perimeter_t;

    perimeter_t pending_q[$];
    int unsigned mismatch_count;
    int unsigned failure_count;

    function new();
        mismatch_count = 0;
        failure_count  = 0;
    endfunction

    // floor(num * 2^30 / den) for num < den; num == den yields 2^30 - 1
    static function logic [63:0] fraction_div(logic [63:0] num, logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = num;
        quo = 0;
        for (int i = 0; i < epa_pkg::Q; i++) begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= den) begin
                rem = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    static function logic [63:0] int_root(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_w;
        res = 0;
        bit_w = 64'd1 << 62;
        while (bit_w > v) bit_w = bit_w >> 2;
        while (bit_w != 0) begin
            if (v >= res + bit_w) begin
                v = v - (res + bit_w);
                res = (res >> 1) + bit_w;
            end else begin
                res = res >> 1;
            end
            bit_w = bit_w >> 2;
        end
        return res;
    endfunction

    static function perimeter_t predict_perimeter(logic [15:0] a_in, logic [15:0] b_in,
                                                  logic radii);
        perimeter_t  res;
        logic [63:0] a, b, s, d, r, h, root, q, f, g;
        logic [127:0] prod;
        a = a_in;
        b = b_in;
        if (radii) begin
            a = (a > 64'h7FFF) ? 64'hFFFF : (a << 1);
            b = (b > 64'h7FFF) ? 64'hFFFF : (b << 1);
        end
        s = a + b;
        if (s == 0) begin
            res.perimeter  = '0;
            res.degenerate = 1'b1;
            return res;
        end
        d = (a > b) ? a - b : b - a;
        r = fraction_div(d, s);
        h = (r * r + (64'd1 << 29)) >> 30;
        root = int_root(((64'd4 << 30) - 3 * h) << 30);
        q = fraction_div(3 * h, (64'd10 << 30) + root);
        f = (64'd1 << 30) + q;
        g = (f * 64'(epa_pkg::PI_Q30) + (64'd1 << 29)) >> 30;
        prod = (128'(s) * 128'(g) + (128'd1 << 29)) >> 30;
        res.perimeter  = (prod > 128'h7FFFF) ? 19'h7FFFF : prod[18:0];
        res.degenerate = 1'b0;
        return res;
    endfunction

    function void note_request(logic [15:0] a, logic [15:0] b, logic radii);
        pending_q = {pending_q, predict_perimeter(a, b, radii)};
    endfunction

    function void check_result(logic [18:0] perimeter, logic degenerate);
        perimeter_t exp_r;
        logic [19:0] diff;
        if (pending_q.size() == 0) begin
            failure_count++;
            if (mismatch_count++ < 10)
                $display("unexpected result perimeter=%0d degenerate=%0b",
                         perimeter, degenerate);
            return;
        end
        exp_r = pending_q.pop_front();
        diff = (perimeter > exp_r.perimeter) ? perimeter - exp_r.perimeter
                                             : exp_r.perimeter - perimeter;
        // allow one LSB on the perimeter
        if (diff > 1 || degenerate !== exp_r.degenerate || $isunknown(perimeter)) begin
            failure_count++;
            if (mismatch_count++ < 10)
                $display("mismatch: expected perimeter=%0d degenerate=%0b, got %0d %0b",
                         exp_r.perimeter, exp_r.degenerate, perimeter, degenerate);
        end
    endfunction
endclass

module testbench;
    localparam int LATENCY     = 97;
    localparam int CYCLE_LIMIT = 200000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [15:0] i_axis_a;
    logic [15:0] i_axis_b;
    logic        i_given_as_radii;
    logic        o_valid;
    logic        i_ready;
    logic [18:0] o_perimeter_value;
    logic        o_degenerate;

    perimeter_scoreboard board;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned cycle_count;

    ellipse_perimeter_approx u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_axis_a          (i_axis_a),
        .i_axis_b          (i_axis_b),
        .i_given_as_radii  (i_given_as_radii),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_perimeter_value (o_perimeter_value),
        .o_degenerate      (o_degenerate)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        board = new();
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_axis_a = '0;
        i_axis_b = '0;
        i_given_as_radii = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        cycle_count = 0;
    end

    // timeout watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** ellipse_perimeter_approx: FAILED **");
            $finish;
        end
    end

    // receiver: random stall, check on accept
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_result(o_perimeter_value, o_degenerate);
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_request(logic [15:0] a, logic [15:0] b, logic radii);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_axis_a         <= a;
        i_axis_b         <= b;
        i_given_as_radii <= radii;
        do @(posedge i_clk); while (!o_ready);
        board.note_request(a, b, radii);
    endtask

    function automatic logic [15:0] random_length();
        case ($urandom_range(4))
            0: return 16'($urandom_range(15));
            1: return 16'($urandom_range(16'h7FFF, 16'h8001));
            2: return 16'hFFFF - 16'($urandom_range(3));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        logic [15:0] a;
        logic [15:0] b;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero axes, extremes, equal axes, saturating radii
        for (int radii = 0; radii < 2; radii++) begin
            send_request(16'h0000, 16'h0000, radii[0]);
            send_request(16'hFFFF, 16'hFFFF, radii[0]);
            send_request(16'hFFFF, 16'h0000, radii[0]);
            send_request(16'h0000, 16'h0001, radii[0]);
            send_request(16'h0001, 16'h0001, radii[0]);
            send_request(16'h7FFF, 16'h8000, radii[0]);
            send_request(16'h8000, 16'h0010, radii[0]);
            send_request(16'h5555, 16'hAAAA, radii[0]);
            send_request(16'h0010, 16'h0010, radii[0]);
        end

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 34 : (phase == 1) ? 61 : 0;
            recv_idle_pct = (phase == 0) ? 61 : (phase == 1) ? 34 : 0;
            for (int n = 0; n < 430; n++) begin
                a = random_length();
                b = ($urandom_range(9) == 0) ? a : random_length();
                send_request(a, b, 1'($urandom));
            end
        end
        i_valid <= 1'b0;

        while (board.pending_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (board.failure_count == 0)
            $display("** ellipse_perimeter_approx: PASSED **");
        else
            $display("** ellipse_perimeter_approx: FAILED **");
        $finish;
    end
endmodule

`default_nettype wire

FILE: filelist.f
+incdir+hdl
hdl/epa_pkg.sv
hdl/epa_div_cell.sv
hdl/epa_sqrt_cell.sv
hdl/ellipse_perimeter_approx.sv
bench/testbench.sv
